// File: rtl/core/small_matrix_add_sub_mul_engine_defines.svh
// Assertion macros shared by the matrix engine checker.
// Needs signals named clock and reset in the scope that uses them.
`ifndef SMALL_MATRIX_ADD_SUB_MUL_ENGINE_DEFINES_SVH
`define SMALL_MATRIX_ADD_SUB_MUL_ENGINE_DEFINES_SVH

// Checked on every clock, ignored while reset is high.
`define SMASE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock, reset included.
`define SMASE_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: rtl/core/smase_pkg.sv
// Shared types and codes for the small matrix add/sub/mul engine.
// Used by the controller, the datapath, the top level and the checker.
package smase_pkg;

   localparam int ELEM_W      = 32;  // element and result width
   localparam int DIM_CFG_W   = 4;   // width of a dimension register
   localparam int MODE_W      = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 4;
   localparam int MAX_DIM_DEF = 8;

   // op_mode codes
   localparam logic [MODE_W-1:0] OP_ADD = 2'd0;
   localparam logic [MODE_W-1:0] OP_SUB = 2'd1;
   localparam logic [MODE_W-1:0] OP_MUL = 2'd2;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_OP_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_A  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_B  = 2'd3;

   // operation field of an input word
   localparam logic ELEM_A = 1'b0;
   localparam logic ELEM_B = 1'b1;

   // travels with a read down the datapath pipe
   typedef struct packed {
      logic [MODE_W-1:0] op;
      logic              first;      // first term of a result element
      logic              last_k;     // last term of a result element
      logic              last_elem;  // last element of the result matrix
   } tag_type;

   typedef struct packed {
      logic    wr_a;
      logic    wr_b;
      logic    rd_en;
      tag_type tag;
   } cmd_type;

   typedef struct packed {
      logic out_free;  // output register empty or being taken
      logic done;      // a finished element lands in the output register
   } sts_type;

endpackage

// File: rtl/core/smase_dp.sv
// Datapath: both matrix memories, read stage, shared add/sub/mul unit,
// accumulator that doubles as the output register. Uses smase_pkg.
module smase_dp #(
   parameter int MAX_DIM = smase_pkg::MAX_DIM_DEF,
   localparam int AW     = (MAX_DIM * MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  smase_pkg::cmd_type            cmd,
   input  logic [AW-1:0]                 wr_addr,
   input  logic [smase_pkg::ELEM_W-1:0]  wr_data,
   input  logic [AW-1:0]                 rd_a_addr,
   input  logic [AW-1:0]                 rd_b_addr,
   output smase_pkg::sts_type            sts,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [smase_pkg::ELEM_W-1:0]  rsp_tdata,
   output logic                          rsp_tlast
);

   localparam int CELLS = MAX_DIM * MAX_DIM;
   localparam int EW    = smase_pkg::ELEM_W;

   logic [EW-1:0] a_mem_ff [CELLS];
   logic [EW-1:0] b_mem_ff [CELLS];

   logic [EW-1:0] a_rd_ff, b_rd_ff;
   logic          s1_valid_ff;
   smase_pkg::tag_type s1_tag_ff;

   logic [EW-1:0] prod_ff, prod_in;
   logic          s2_valid_ff;
   smase_pkg::tag_type s2_tag_ff;

   logic [EW-1:0] acc_ff, acc_in;
   logic          out_valid_ff, out_valid_in;
   logic          out_last_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_a) begin
         a_mem_ff[wr_addr] <= wr_data;
      end
      if (cmd.wr_b) begin
         b_mem_ff[wr_addr] <= wr_data;
      end
      a_rd_ff <= a_mem_ff[rd_a_addr];
      b_rd_ff <= b_mem_ff[rd_b_addr];
   end

   always_comb begin
      case (s1_tag_ff.op)
         smase_pkg::OP_MUL: prod_in = a_rd_ff * b_rd_ff;
         smase_pkg::OP_SUB: prod_in = a_rd_ff - b_rd_ff;
         default:           prod_in = a_rd_ff + b_rd_ff;
      endcase
   end

   always_comb begin
      acc_in       = acc_ff;
      out_valid_in = out_valid_ff;
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (s2_valid_ff) begin
         acc_in = s2_tag_ff.first ? prod_ff : acc_ff + prod_ff;
         if (s2_tag_ff.last_k) begin
            out_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= cmd.rd_en;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= out_valid_in;
      end
      s1_tag_ff <= cmd.tag;
      s2_tag_ff <= s1_tag_ff;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      if (s2_valid_ff && s2_tag_ff.last_k) begin
         out_last_ff <= s2_tag_ff.last_elem;
      end
   end

   assign sts.out_free = !out_valid_ff || rsp_tready;
   assign sts.done     = s2_valid_ff && s2_tag_ff.last_k;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = acc_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// File: rtl/core/smase_ctrl.sv
// Controller: configuration registers, load counters and the sequencer
// that walks result elements and their terms. Uses smase_pkg.
module smase_ctrl #(
   parameter int MAX_DIM = smase_pkg::MAX_DIM_DEF,
   localparam int AW     = (MAX_DIM * MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [smase_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [smase_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic                             req_tuser,
   input  smase_pkg::sts_type               sts,
   output smase_pkg::cmd_type               cmd,
   output logic [AW-1:0]                    wr_addr,
   output logic [AW-1:0]                    rd_a_addr,
   output logic [AW-1:0]                    rd_b_addr
);

   localparam int CELLS = MAX_DIM * MAX_DIM;
   localparam int CW    = $clog2(CELLS + 1);
   localparam int DW    = $clog2(MAX_DIM + 1);
   localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int LW    = 2 * DW;
   localparam int DCW   = smase_pkg::DIM_CFG_W;

   localparam logic [1:0] ST_LOAD  = 2'd0;
   localparam logic [1:0] ST_HOLD  = 2'd1;
   localparam logic [1:0] ST_ISSUE = 2'd2;
   localparam logic [1:0] ST_WAIT  = 2'd3;

   function automatic logic [DW-1:0] clamp_dim(input logic [DCW-1:0] d);
      if (d == '0) begin
         return DW'(1);
      end else if (int'(d) > MAX_DIM) begin
         return DW'(MAX_DIM);
      end else begin
         return DW'(d);
      end
   endfunction

   logic [smase_pkg::MODE_W-1:0] mode_ff;
   logic [DCW-1:0]               rows_ff, inner_ff, cols_ff;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] a_cnt_ff, a_cnt_in, b_cnt_ff, b_cnt_in;
   logic [IW-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;

   logic [DW-1:0] m, n, p, r_cols;
   logic          mul;
   logic [smase_pkg::MODE_W-1:0] op;
   logic [LW-1:0] a_size_w, b_size_w, a_lin, b_lin, e_lin;
   logic [CW-1:0] a_size, b_size;
   logic          b_done, last_row, last_col, last_k, accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= smase_pkg::OP_ADD;
         rows_ff  <= DCW'(1);
         inner_ff <= DCW'(1);
         cols_ff  <= DCW'(1);
      end else if (csr_wr_en) begin
         case (csr_index)
            smase_pkg::CSR_OP_MODE: mode_ff  <= csr_wdata[smase_pkg::MODE_W-1:0];
            smase_pkg::CSR_ROWS_A:  rows_ff  <= csr_wdata;
            smase_pkg::CSR_INNER:   inner_ff <= csr_wdata;
            smase_pkg::CSR_COLS_B:  cols_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign m      = clamp_dim(rows_ff);
   assign n      = clamp_dim(inner_ff);
   assign p      = clamp_dim(cols_ff);
   assign mul    = (mode_ff == smase_pkg::OP_MUL);
   // unused mode 3 runs as add
   assign op     = mul ? smase_pkg::OP_MUL :
                   (mode_ff == smase_pkg::OP_SUB) ? smase_pkg::OP_SUB : smase_pkg::OP_ADD;
   assign r_cols = mul ? p : n;

   assign a_size_w = LW'(m) * LW'(n);
   assign b_size_w = mul ? LW'(n) * LW'(p) : a_size_w;
   assign a_size   = a_size_w[CW-1:0];
   assign b_size   = b_size_w[CW-1:0];

   assign accept = req_tvalid && req_tready;
   // B completes on this word, also when it already held its full size
   assign b_done = ({1'b0, b_cnt_ff} + 1'b1) >= {1'b0, b_size};

   assign last_row = (DW'(i_ff) == m - 1'b1);
   assign last_col = (DW'(j_ff) == r_cols - 1'b1);
   assign last_k   = !mul || (DW'(k_ff) == n - 1'b1);

   // A[i][k] and B[k][j] when multiplying, A[i][j] and B[i][j] otherwise
   assign e_lin = LW'(i_ff) * LW'(n) + LW'(j_ff);
   assign a_lin = mul ? LW'(i_ff) * LW'(n) + LW'(k_ff) : e_lin;
   assign b_lin = mul ? LW'(k_ff) * LW'(p) + LW'(j_ff) : e_lin;

   assign rd_a_addr  = a_lin[AW-1:0];
   assign rd_b_addr  = b_lin[AW-1:0];
   assign wr_addr    = (req_tuser == smase_pkg::ELEM_B) ? b_cnt_ff[AW-1:0] : a_cnt_ff[AW-1:0];
   assign req_tready = (state_ff == ST_LOAD);

   always_comb begin
      state_in = state_ff;
      a_cnt_in = a_cnt_ff;
      b_cnt_in = b_cnt_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      cmd      = '0;
      cmd.tag.op        = op;
      cmd.tag.first     = (k_ff == '0);
      cmd.tag.last_k    = last_k;
      cmd.tag.last_elem = last_row && last_col && last_k;
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (req_tuser == smase_pkg::ELEM_B) begin
                  if (b_cnt_ff < b_size) begin
                     cmd.wr_b = 1'b1;
                     b_cnt_in = b_cnt_ff + 1'b1;
                  end
                  if (b_done) begin
                     a_cnt_in = '0;
                     b_cnt_in = '0;
                     i_in     = '0;
                     j_in     = '0;
                     k_in     = '0;
                     state_in = ST_HOLD;
                  end
               end else if (a_cnt_ff < a_size) begin
                  cmd.wr_a = 1'b1;
                  a_cnt_in = a_cnt_ff + 1'b1;
               end
            end
         end
         ST_HOLD: begin
            if (sts.out_free) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            cmd.rd_en = 1'b1;
            if (last_k) begin
               k_in     = '0;
               state_in = ST_WAIT;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_WAIT: begin
            if (sts.done) begin
               if (last_row && last_col) begin
                  state_in = ST_LOAD;
               end else begin
                  if (last_col) begin
                     j_in = '0;
                     i_in = i_ff + 1'b1;
                  end else begin
                     j_in = j_ff + 1'b1;
                  end
                  state_in = ST_HOLD;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         a_cnt_ff <= '0;
         b_cnt_ff <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         a_cnt_ff <= a_cnt_in;
         b_cnt_ff <= b_cnt_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

endmodule

// File: rtl/core/small_matrix_add_sub_mul_engine.sv
// Small integer matrix engine. Load matrix A, then matrix B, one signed
// 32-bit word per element in row-major order (req_tuser 0 for A, 1 for B).
// The word that completes B starts the computation; the result streams out
// in row-major order with rsp_tlast on its final element. op_mode 0 adds,
// 1 subtracts (A - B), 2 multiplies (A is rows_a x inner_size, B is
// inner_size x cols_b); all results wrap to 32 bits. Dimensions of 0 read
// as 1, above MAX_DIM as MAX_DIM. Extra A words past A's size are dropped.
// Write the csr registers only while the engine is idle.
// Timing: load words are taken one per cycle while req_tready is high. A
// result element starts once the output register is free and then issues
// its terms, inner_size when multiplying and one otherwise, at one term per
// cycle through the single read port of each matrix memory and the one
// shared multiply/add unit, then through read, operate and accumulate stages.
// Loading of the next pair may begin while the final result word still
// waits in the output register.
// Depends on smase_pkg, smase_ctrl, smase_dp.
module small_matrix_add_sub_mul_engine #(
   parameter int MAX_DIM = smase_pkg::MAX_DIM_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // input word stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [smase_pkg::ELEM_W-1:0]     req_tdata,   // [31:0] element_value
   input  logic                             req_tuser,   // [0] operation
   // result word stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [smase_pkg::ELEM_W-1:0]     rsp_tdata,   // [31:0] result_value
   output logic                             rsp_tlast,   // is_last
   // register writes: 0 op_mode, 1 rows_a, 2 inner_size, 3 cols_b
   input  logic                             csr_wr_en,
   input  logic [smase_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [smase_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int CELLS = MAX_DIM * MAX_DIM;
   localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

   smase_pkg::cmd_type cmd;
   smase_pkg::sts_type sts;
   logic [AW-1:0]      wr_addr, rd_a_addr, rd_b_addr;

   // counters, config and sequencing
   smase_ctrl #(
      .MAX_DIM (MAX_DIM)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .sts        (sts),
      .cmd        (cmd),
      .wr_addr    (wr_addr),
      .rd_a_addr  (rd_a_addr),
      .rd_b_addr  (rd_b_addr)
   );

   // memories, arithmetic and the output register
   smase_dp #(
      .MAX_DIM (MAX_DIM)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .wr_addr    (wr_addr),
      .wr_data    (req_tdata),
      .rd_a_addr  (rd_a_addr),
      .rd_b_addr  (rd_b_addr),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: rtl/core/smase_chk.sv
// Port-level checker for the matrix engine, bound to the top level.
// Depends on smase_pkg and small_matrix_add_sub_mul_engine_defines.svh.
`include "small_matrix_add_sub_mul_engine_defines.svh"

module smase_chk (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tvalid,
   input logic                         req_tready,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [smase_pkg::ELEM_W-1:0] rsp_tdata,
   input logic                         rsp_tlast
);

   // a stalled result word holds
   `SMASE_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "rsp word changed while stalled")

   // nothing pending after reset
   `SMASE_ASSERT_ALWAYS(a_rsp_reset, reset |=> !rsp_tvalid, "rsp_tvalid set after reset")

   // loading stays closed while a result word other than the final one is pending
   `SMASE_ASSERT(a_no_load_mid, rsp_tvalid && !rsp_tlast |-> !req_tready, "input open mid-result")

   // no result word rises directly after an accepted input word
   `SMASE_ASSERT(a_rsp_latency, $rose(rsp_tvalid) |-> !$past(req_tvalid && req_tready), "result too early")

endmodule

bind small_matrix_add_sub_mul_engine smase_chk u_chk (.*);

// File: tb/small_matrix_add_sub_mul_engine_tb.sv
// Self-checking bench for small_matrix_add_sub_mul_engine: streams matrix pairs in,
// predicts every result word locally and checks the rsp stream word by word.
// Depends on smase_pkg and the engine RTL; reads no files.
module small_matrix_add_sub_mul_engine_tb;
   import smase_pkg::*;

   localparam logic [MODE_W-1:0] OP_SPARE = 2'd3;   // unused code, engine treats it as add
   localparam int CELLS      = MAX_DIM_DEF * MAX_DIM_DEF;
   localparam int SETTLE     = 16;       // idle margin after a drain, sized for the largest inner size
   localparam int RAND_WORDS = 350;      // on top of about 150 directed words

   // one word on the req stream
   typedef struct packed {
      logic              which;    // ELEM_A or ELEM_B
      logic [ELEM_W-1:0] value;
   } load_word_type;

   // one word on the rsp stream
   typedef struct packed {
      logic [ELEM_W-1:0] value;
      logic              last;
   } result_word_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [ELEM_W-1:0]     req_tdata  = '0;   // [31:0] element_value
   logic                  req_tuser  = 1'b0; // [0] operation
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [ELEM_W-1:0]     rsp_tdata;         // [31:0] result_value
   logic                  rsp_tlast;
   logic                  csr_wr_en  = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   load_word_type   load_q[$];        // words waiting for the driver
   result_word_type results_due[$];   // predicted rsp words, oldest first
   load_word_type   held_word;        // word currently offered on req
   result_word_type due_word;
   bit           word_busy  = 1'b0;
   bit           steady     = 1'b0;  // no idling on either side while set
   int           err_count  = 0;
   int           rand_words = 0;
   int           phase_no   = 0;

   // bench-side copy of the engine state
   logic [ELEM_W-1:0]    mat_a [CELLS];
   logic [ELEM_W-1:0]    mat_b [CELLS];
   int                   a_fill;
   int                   b_fill;
   logic [MODE_W-1:0]    mode_reg;
   logic [DIM_CFG_W-1:0] rows_reg;
   logic [DIM_CFG_W-1:0] inner_reg;
   logic [DIM_CFG_W-1:0] cols_reg;

   small_matrix_add_sub_mul_engine #(.MAX_DIM(MAX_DIM_DEF)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // dimension as the engine sees it: 0 reads as 1, above MAX_DIM as MAX_DIM
   function automatic int eff_dim(logic [DIM_CFG_W-1:0] d);
      if (d == 0) return 1;
      if (d > MAX_DIM_DEF) return MAX_DIM_DEF;
      return int'(d);
   endfunction

   // Apply one accepted word to the local state; when it completes B, queue
   // the whole result matrix in row-major order.
   function automatic void predict_load(load_word_type w);
      int m, n, p, a_size, b_size, r_cols, i, j, k;
      bit mul;
      logic [ELEM_W-1:0] acc;
      result_word_type r;
      m      = eff_dim(rows_reg);
      n      = eff_dim(inner_reg);
      p      = eff_dim(cols_reg);
      mul    = (mode_reg == OP_MUL);
      a_size = m * n;
      b_size = mul ? n * p : m * n;
      r_cols = mul ? p : n;
      if (w.which == ELEM_A) begin
         // extra A words past the current size are dropped
         if (a_fill < a_size) begin
            mat_a[a_fill] = w.value;
            a_fill++;
         end
         return;
      end
      // B already full under a shrunk size: word dropped, result goes out now
      if (b_fill < b_size) begin
         mat_b[b_fill] = w.value;
         b_fill++;
      end
      if (b_fill < b_size) return;
      for (i = 0; i < m; i++) begin
         for (j = 0; j < r_cols; j++) begin
            if (mul) begin
               acc = '0;
               for (k = 0; k < n; k++) acc += mat_a[i*n + k] * mat_b[k*p + j];
            end else if (mode_reg == OP_SUB) begin
               acc = mat_a[i*n + j] - mat_b[i*n + j];
            end else begin
               acc = mat_a[i*n + j] + mat_b[i*n + j];   // add and the spare code
            end
            r.value = acc;
            r.last  = (i == m - 1) && (j == r_cols - 1);
            results_due.push_back(r);
         end
      end
      a_fill = 0;
      b_fill = 0;
   endfunction

   // Driver: offers queued words, idles at random, predicts on acceptance.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_load(held_word);
            word_busy = 1'b0;
         end
         if (!req_tvalid || req_tready) begin
            if (load_q.size() > 0 && (steady || $urandom_range(0, 99) >= 33)) begin
               held_word = load_q.pop_front();
               word_busy = 1'b1;
               req_tvalid <= 1'b1;
               req_tdata  <= held_word.value;
               req_tuser  <= held_word.which;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: stalls at random, checks each accepted rsp word against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (results_due.size() == 0) begin
            $display("%0t unexpected result word: expected none, actual %h last %b",
                     $time, rsp_tdata, rsp_tlast);
            err_count++;
         end else begin
            due_word = results_due.pop_front();
            if (rsp_tdata !== due_word.value) begin
               $display("%0t result_value mismatch: expected %h, actual %h",
                        $time, due_word.value, rsp_tdata);
               err_count++;
            end
            if (rsp_tlast !== due_word.last) begin
               $display("%0t is_last mismatch: expected %b, actual %b",
                        $time, due_word.last, rsp_tlast);
               err_count++;
            end
         end
      end
      rsp_tready <= steady || ($urandom_range(0, 99) >= 33);
   end

   function automatic void add_word(logic which, logic [ELEM_W-1:0] value);
      load_word_type w;
      w.which = which;
      w.value = value;
      load_q.push_back(w);
   endfunction

   // mostly random, with the sign/zero extremes mixed in
   function automatic logic [ELEM_W-1:0] pick_value();
      case ($urandom_range(0, 11))
         0: begin
            return {1'b1, {(ELEM_W-1){1'b0}}};
         end
         1: begin
            return {1'b0, {(ELEM_W-1){1'b1}}};
         end
         2: begin
            return '0;
         end
         3: begin
            return '1;
         end
         default: begin
            return ELEM_W'($urandom);
         end
      endcase
   endfunction

   // mostly small sizes; now and then 0 or something at or past MAX_DIM
   function automatic logic [DIM_CFG_W-1:0] pick_dim();
      int r;
      r = $urandom_range(0, 99);
      if (r < 6) return '0;
      if (r < 12) return DIM_CFG_W'($urandom_range(MAX_DIM_DEF, 15));
      return DIM_CFG_W'($urandom_range(1, 4));
   endfunction

   // one csr write; local copy updated now, the engine is idle
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_OP_MODE: begin
            mode_reg = data[MODE_W-1:0];
         end
         CSR_ROWS_A: begin
            rows_reg = data;
         end
         CSR_INNER: begin
            inner_reg = data;
         end
         default: begin
            cols_reg = data;
         end
      endcase
   endtask

   task automatic configure(logic [CSR_DATA_W-1:0] mode_w, logic [CSR_DATA_W-1:0] rows,
                            logic [CSR_DATA_W-1:0] inner, logic [CSR_DATA_W-1:0] cols);
      write_reg(CSR_OP_MODE, mode_w);
      write_reg(CSR_ROWS_A, rows);
      write_reg(CSR_INNER, inner);
      write_reg(CSR_COLS_B, cols);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // wait until every word is in and every predicted word is out, then let
   // the engine finish anything that produces no result
   task automatic drain();
      while (load_q.size() > 0 || word_busy || results_due.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // One random phase: maybe a new setting, then one to three pairs. Most pairs
   // are clean A-then-B loads; the rest carry extra A, short A, interleaved
   // A/B, or stop with B half loaded so the next setting may shrink under it.
   task automatic random_phase();
      int m, n, p, a_size, b_size, pairs, kind, na, nb, q, s;
      logic [MODE_W-1:0] mode;
      logic [CSR_DATA_W-1:0] mode_w;
      if ($urandom_range(0, 99) < 85) begin
         mode = ($urandom_range(0, 99) < 40) ? OP_MUL : MODE_W'($urandom_range(0, 3));
         mode_w = CSR_DATA_W'($urandom);   // upper bits are don't-care for op_mode
         mode_w[MODE_W-1:0] = mode;
         configure(mode_w, pick_dim(), pick_dim(), pick_dim());
      end
      m      = eff_dim(rows_reg);
      n      = eff_dim(inner_reg);
      p      = eff_dim(cols_reg);
      a_size = m * n;
      b_size = (mode_reg == OP_MUL) ? n * p : m * n;
      pairs  = $urandom_range(1, 3);
      for (q = 0; q < pairs; q++) begin
         kind = $urandom_range(0, 99);
         na   = a_size;
         nb   = b_size;
         if (kind >= 75 && kind < 82) na = a_size + $urandom_range(1, 3);
         else if (kind >= 82 && kind < 89) na = $urandom_range(0, a_size - 1);
         else if (kind >= 95 && b_size > 1) nb = $urandom_range(1, b_size - 1);
         rand_words += na + nb;
         if (kind >= 89 && kind < 95) begin
            while (na + nb > 0) begin
               if (nb == 0 || (na > 0 && $urandom_range(0, 1) == 1)) begin
                  add_word(ELEM_A, pick_value());
                  na--;
               end else begin
                  add_word(ELEM_B, pick_value());
                  nb--;
               end
            end
         end else begin
            for (s = 0; s < na; s++) add_word(ELEM_A, pick_value());
            for (s = 0; s < nb; s++) add_word(ELEM_B, pick_value());
         end
         if (nb < b_size) break;   // half-loaded B stays for the next phase
      end
   endtask

   initial begin
      a_fill    = 0;
      b_fill    = 0;
      mode_reg  = OP_ADD;
      rows_reg  = 1;
      inner_reg = 1;
      cols_reg  = 1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Full 8x8 add first: every entry of both stores gets written, so a
      // short A load later only ever reads stale, never unwritten, entries.
      configure(OP_ADD, MAX_DIM_DEF, MAX_DIM_DEF, MAX_DIM_DEF);
      for (int s = 0; s < CELLS; s++) add_word(ELEM_A, pick_value());
      for (int s = 0; s < CELLS; s++) add_word(ELEM_B, pick_value());
      drain();

      // 1x1 add that overflows
      configure(OP_ADD, 1, 1, 1);
      add_word(ELEM_A, 32'h7fff_ffff);
      add_word(ELEM_B, 32'h0000_0001);
      drain();

      // 1x2 subtract at the negative extreme
      configure(OP_SUB, 1, 2, 1);
      add_word(ELEM_A, 32'h8000_0000);
      add_word(ELEM_A, 32'h0000_0000);
      add_word(ELEM_B, 32'h0000_0001);
      add_word(ELEM_B, 32'h8000_0000);
      drain();

      // 2x2 multiply with wrapping products
      configure(OP_MUL, 2, 2, 2);
      add_word(ELEM_A, 32'h7fff_ffff);
      add_word(ELEM_A, 32'h8000_0000);
      add_word(ELEM_A, 32'hffff_ffff);
      add_word(ELEM_A, 32'h0000_0002);
      add_word(ELEM_B, 32'h7fff_ffff);
      add_word(ELEM_B, 32'hffff_ffff);
      add_word(ELEM_B, 32'h8000_0000);
      add_word(ELEM_B, 32'h0000_0001);
      drain();

      // spare mode code acts as add; zero dims read as 1; second A is dropped
      configure(OP_SPARE, 0, 0, 0);
      add_word(ELEM_A, 32'h1234_5678);
      add_word(ELEM_A, 32'hdead_beef);
      add_word(ELEM_B, 32'h0101_0101);
      drain();

      // B completes before A: A's second entry is stale
      configure(OP_ADD, 1, 2, 1);
      add_word(ELEM_A, 32'h0000_0005);
      add_word(ELEM_B, 32'h0000_0007);
      add_word(ELEM_B, 32'hffff_fff0);
      drain();

      // shrink under a half-loaded B: next B word is dropped and result goes out
      configure(OP_MUL, 1, 2, 2);
      add_word(ELEM_B, 32'h0000_0003);
      add_word(ELEM_B, 32'h0000_0004);
      add_word(ELEM_B, 32'h0000_0006);
      drain();
      configure(OP_MUL, 1, 2, 1);
      add_word(ELEM_B, 32'h7777_7777);
      drain();

      while (rand_words < RAND_WORDS) begin
         steady = (phase_no >= 3 && phase_no < 7);
         random_phase();
         drain();
         phase_no++;
      end
      steady = 1'b0;
      repeat (4 * SETTLE) @(posedge clock);   // catch stray result words
      if (err_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2400000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
